[rtl/core/mex_pkg.sv]
// Shared types and operation codes for the MIPS execute unit.
package mex_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CODE_W = 6;

    localparam logic KIND_RTYPE = 1'b0;
    localparam logic KIND_OTHER = 1'b1;

    localparam logic [CODE_W-1:0] FN_SLL   = 6'd0;
    localparam logic [CODE_W-1:0] FN_SRL   = 6'd2;
    localparam logic [CODE_W-1:0] FN_SRA   = 6'd3;
    localparam logic [CODE_W-1:0] FN_SLLV  = 6'd4;
    localparam logic [CODE_W-1:0] FN_SRLV  = 6'd6;
    localparam logic [CODE_W-1:0] FN_SRAV  = 6'd7;
    localparam logic [CODE_W-1:0] FN_JR    = 6'd8;
    localparam logic [CODE_W-1:0] FN_JALR  = 6'd9;
    localparam logic [CODE_W-1:0] FN_MFHI  = 6'd16;
    localparam logic [CODE_W-1:0] FN_MTHI  = 6'd17;
    localparam logic [CODE_W-1:0] FN_MFLO  = 6'd18;
    localparam logic [CODE_W-1:0] FN_MTLO  = 6'd19;
    localparam logic [CODE_W-1:0] FN_ADD   = 6'd32;
    localparam logic [CODE_W-1:0] FN_ADDU  = 6'd33;
    localparam logic [CODE_W-1:0] FN_SUB   = 6'd34;
    localparam logic [CODE_W-1:0] FN_SUBU  = 6'd35;
    localparam logic [CODE_W-1:0] FN_AND   = 6'd36;
    localparam logic [CODE_W-1:0] FN_OR    = 6'd37;
    localparam logic [CODE_W-1:0] FN_XOR   = 6'd38;
    localparam logic [CODE_W-1:0] FN_NOR   = 6'd39;
    localparam logic [CODE_W-1:0] FN_SLT   = 6'd42;
    localparam logic [CODE_W-1:0] FN_SLTU  = 6'd43;

    localparam logic [CODE_W-1:0] OPC_J     = 6'd2;
    localparam logic [CODE_W-1:0] OPC_JAL   = 6'd3;
    localparam logic [CODE_W-1:0] OPC_BLEZ  = 6'd6;
    localparam logic [CODE_W-1:0] OPC_ADDI  = 6'd8;
    localparam logic [CODE_W-1:0] OPC_ADDIU = 6'd9;
    localparam logic [CODE_W-1:0] OPC_SLTI  = 6'd10;
    localparam logic [CODE_W-1:0] OPC_SLTIU = 6'd11;
    localparam logic [CODE_W-1:0] OPC_ANDI  = 6'd12;
    localparam logic [CODE_W-1:0] OPC_ORI   = 6'd13;
    localparam logic [CODE_W-1:0] OPC_XORI  = 6'd14;
    localparam logic [CODE_W-1:0] OPC_LUI   = 6'd15;
    localparam logic [CODE_W-1:0] OPC_LB    = 6'd32;
    localparam logic [CODE_W-1:0] OPC_LH    = 6'd33;
    localparam logic [CODE_W-1:0] OPC_LW    = 6'd35;
    localparam logic [CODE_W-1:0] OPC_LBU   = 6'd36;
    localparam logic [CODE_W-1:0] OPC_LHU   = 6'd37;
    localparam logic [CODE_W-1:0] OPC_SB    = 6'd40;
    localparam logic [CODE_W-1:0] OPC_SH    = 6'd41;
    localparam logic [CODE_W-1:0] OPC_SW    = 6'd43;

    localparam int unsigned LUI_SHIFT = 16;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_AND,
        OP_OR,
        OP_XOR,
        OP_NOR,
        OP_SLT,
        OP_SLTU,
        OP_SLL,
        OP_SRL,
        OP_SRA,
        OP_JR,
        OP_JALR,
        OP_MOVE,
        OP_LUI,
        OP_BLEZ,
        OP_JUMP,
        OP_JAL
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    is_load;
        logic    unknown;
    } dec_ctrl_t;

endpackage

[rtl/core/mex_decode.sv]
// Instruction class and code decoder for the MIPS execute unit.
module mex_decode (
    input  logic                          kind,
    input  logic [mex_pkg::CODE_W-1:0]    code,
    output mex_pkg::dec_ctrl_t            ctrl
);

    always_comb
    begin
        ctrl.op      = mex_pkg::OP_NONE;
        ctrl.is_load = 1'b0;
        ctrl.unknown = 1'b0;
        if (kind == mex_pkg::KIND_RTYPE)
        begin
            unique case (code) inside
                mex_pkg::FN_ADD, mex_pkg::FN_ADDU:   ctrl.op = mex_pkg::OP_ADD;
                mex_pkg::FN_SUB, mex_pkg::FN_SUBU:   ctrl.op = mex_pkg::OP_SUB;
                mex_pkg::FN_AND:                     ctrl.op = mex_pkg::OP_AND;
                mex_pkg::FN_OR:                      ctrl.op = mex_pkg::OP_OR;
                mex_pkg::FN_XOR:                     ctrl.op = mex_pkg::OP_XOR;
                mex_pkg::FN_NOR:                     ctrl.op = mex_pkg::OP_NOR;
                mex_pkg::FN_SLT:                     ctrl.op = mex_pkg::OP_SLT;
                mex_pkg::FN_SLTU:                    ctrl.op = mex_pkg::OP_SLTU;
                mex_pkg::FN_SLL, mex_pkg::FN_SLLV:   ctrl.op = mex_pkg::OP_SLL;
                mex_pkg::FN_SRL, mex_pkg::FN_SRLV:   ctrl.op = mex_pkg::OP_SRL;
                mex_pkg::FN_SRA, mex_pkg::FN_SRAV:   ctrl.op = mex_pkg::OP_SRA;
                mex_pkg::FN_JR:                      ctrl.op = mex_pkg::OP_JR;
                mex_pkg::FN_JALR:                    ctrl.op = mex_pkg::OP_JALR;
                mex_pkg::FN_MFHI, mex_pkg::FN_MTHI,
                mex_pkg::FN_MFLO, mex_pkg::FN_MTLO:  ctrl.op = mex_pkg::OP_MOVE;
                default:                             ctrl.unknown = 1'b1;
            endcase
        end
        else
        begin
            unique case (code) inside
                mex_pkg::OPC_ADDI, mex_pkg::OPC_ADDIU: ctrl.op = mex_pkg::OP_ADD;
                mex_pkg::OPC_SLTI:                     ctrl.op = mex_pkg::OP_SLT;
                mex_pkg::OPC_SLTIU:                    ctrl.op = mex_pkg::OP_SLTU;
                mex_pkg::OPC_ANDI:                     ctrl.op = mex_pkg::OP_AND;
                mex_pkg::OPC_ORI:                      ctrl.op = mex_pkg::OP_OR;
                mex_pkg::OPC_XORI:                     ctrl.op = mex_pkg::OP_XOR;
                mex_pkg::OPC_LUI:                      ctrl.op = mex_pkg::OP_LUI;
                mex_pkg::OPC_BLEZ:                     ctrl.op = mex_pkg::OP_BLEZ;
                mex_pkg::OPC_LB, mex_pkg::OPC_LH, mex_pkg::OPC_LW,
                mex_pkg::OPC_LBU, mex_pkg::OPC_LHU:
                begin
                    ctrl.op      = mex_pkg::OP_ADD;
                    ctrl.is_load = 1'b1;
                end
                mex_pkg::OPC_SB, mex_pkg::OPC_SH, mex_pkg::OPC_SW:
                                                       ctrl.op = mex_pkg::OP_MOVE;
                mex_pkg::OPC_J:                        ctrl.op = mex_pkg::OP_JUMP;
                mex_pkg::OPC_JAL:                      ctrl.op = mex_pkg::OP_JAL;
                default:                               ctrl.unknown = 1'b1;
            endcase
        end
    end

endmodule

[rtl/core/mex_alu.sv]
// Datapath of the MIPS execute unit: value and next program counter.
module mex_alu (
    input  mex_pkg::alu_op_t              op,
    input  logic [mex_pkg::WORD_W-1:0]    x,
    input  logic [mex_pkg::WORD_W-1:0]    y,
    input  logic [mex_pkg::WORD_W-1:0]    pc,
    output logic [mex_pkg::WORD_W-1:0]    value,
    output logic [mex_pkg::WORD_W-1:0]    next_pc
);

    logic [4:0]                  sh;
    logic [mex_pkg::WORD_W-1:0]  jtarget;
    logic                        blez_taken;

    assign sh         = y[4:0];
    assign jtarget    = {pc[31:26], x[23:0], 2'b00};
    assign blez_taken = x[31] | (x == '0);

    always_comb
    begin
        value   = '0;
        next_pc = pc;
        case (op)
            mex_pkg::OP_ADD:  value = x + y;
            mex_pkg::OP_SUB:  value = x - y;
            mex_pkg::OP_AND:  value = x & y;
            mex_pkg::OP_OR:   value = x | y;
            mex_pkg::OP_XOR:  value = x ^ y;
            mex_pkg::OP_NOR:  value = ~(x | y);
            mex_pkg::OP_SLT:  value = {31'd0, $signed(x) < $signed(y)};
            mex_pkg::OP_SLTU: value = {31'd0, x < y};
            mex_pkg::OP_SLL:  value = x << sh;
            mex_pkg::OP_SRL:  value = x >> sh;
            mex_pkg::OP_SRA:  value = $unsigned($signed(x) >>> sh);
            mex_pkg::OP_JR:   next_pc = x;
            mex_pkg::OP_JALR:
            begin
                value   = pc;
                next_pc = y;
            end
            mex_pkg::OP_MOVE: value = x;
            mex_pkg::OP_LUI:  value = x << mex_pkg::LUI_SHIFT;
            mex_pkg::OP_BLEZ:
            begin
                if (blez_taken)
                    next_pc = pc + {y[29:0], 2'b00};
            end
            mex_pkg::OP_JUMP: next_pc = jtarget;
            mex_pkg::OP_JAL:
            begin
                value   = pc;
                next_pc = jtarget;
            end
            default:          value = '0;
        endcase
    end

endmodule

[rtl/core/mips_execute_unit.sv]
// Top level of the MIPS execute unit: input register, decode, datapath, result register.
//
// Usage:
//   Present an instruction beat on kind, code, x_operand, y_operand and
//   current_address with start high; it is taken at the rising edge when
//   busy is low. busy stays low: a new beat may be taken every cycle.
//   The result beat (value, next_address, is_load, unknown_code) is driven
//   with done high for exactly one cycle once the result register has
//   captured it behind the input register; it is taken at the edge that
//   ends that cycle. Results leave in the order the beats came in.
//   The beat passes the input register, then decode and datapath into the
//   result register. Throughput: 1 beat per cycle, set by the single
//   pass through decoder and 32-bit adder/shifter between the registers.
//   Reset (rst_n low, asynchronous) drops any beat in flight and clears
//   done. The receiver cannot stall: each result is taken in its cycle.
module mips_execute_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [5:0]         code,
    input  logic signed [31:0] x_operand,
    input  logic signed [31:0] y_operand,
    input  logic [31:0]        current_address,
    output logic               done,
    output logic signed [31:0] value,
    output logic [31:0]        next_address,
    output logic               is_load,
    output logic               unknown_code
);

    logic                              in_valid_reg;
    logic                              kind_reg;
    logic [mex_pkg::CODE_W-1:0]        code_reg;
    logic [mex_pkg::WORD_W-1:0]        x_reg;
    logic [mex_pkg::WORD_W-1:0]        y_reg;
    logic [mex_pkg::WORD_W-1:0]        pc_reg;

    mex_pkg::dec_ctrl_t                ctrl;
    logic [mex_pkg::WORD_W-1:0]        value_next;
    logic [mex_pkg::WORD_W-1:0]        next_pc_next;

    logic                              done_reg;
    logic [mex_pkg::WORD_W-1:0]        value_reg;
    logic [mex_pkg::WORD_W-1:0]        next_pc_reg;
    logic                              is_load_reg;
    logic                              unknown_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start & ~busy)
        begin
            kind_reg <= kind;
            code_reg <= code;
            x_reg    <= $unsigned(x_operand);
            y_reg    <= $unsigned(y_operand);
            pc_reg   <= current_address;
        end
        if (in_valid_reg)
        begin
            value_reg   <= value_next;
            next_pc_reg <= next_pc_next;
            is_load_reg <= ctrl.is_load;
            unknown_reg <= ctrl.unknown;
        end
    end

    mex_decode u_decode (
        .kind (kind_reg),
        .code (code_reg),
        .ctrl (ctrl)
    );

    mex_alu u_alu (
        .op      (ctrl.op),
        .x       (x_reg),
        .y       (y_reg),
        .pc      (pc_reg),
        .value   (value_next),
        .next_pc (next_pc_next)
    );

    assign done         = done_reg;
    assign value        = $signed(value_reg);
    assign next_address = next_pc_reg;
    assign is_load      = is_load_reg;
    assign unknown_code = unknown_reg;

endmodule

[rtl/core/mex_checker.sv]
// Port-level assertions for the MIPS execute unit and their bind.
module mex_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] value,
    input logic               is_load,
    input logic               unknown_code
);

    a_accept_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted beat did not produce a result two cycles later");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !done)
        else $error("result strobe without an accepted beat");

    a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && unknown_code) |-> (value == 32'sd0 && !is_load))
        else $error("unknown code result carries a value or load mark");

    a_load_known: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_load) |-> !unknown_code)
        else $error("load mark set on an unknown code");

endmodule

bind mips_execute_unit mex_checker u_mex_checker (.*);
